// ===== design/jpbp_pkg.sv =====
`default_nettype none
package jpbp_pkg;

  localparam int unsigned CodeW     = 16;
  localparam int unsigned LenW      = 5;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned MaxBeats  = 4;
  localparam int unsigned CntW      = 3;
  localparam int unsigned AccW      = 24;

  localparam logic [ByteW-1:0] ByteAllOnes = 8'hFF;
  localparam logic [2:0]       TopBitIdx   = 3'd7;
  localparam logic [LenW-1:0]  MaxCodeLen  = 5'd16;

  typedef enum logic {
    ACT_APPEND = 1'b0,
    ACT_FLUSH  = 1'b1
  } action_e;

endpackage
`default_nettype wire

// ===== design/jpbp_if.sv =====
`default_nettype none
interface jpbp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] code_value;
  logic [4:0]  code_length;

  modport source (output valid, action, code_value, code_length, input ready);
  modport sink   (input valid, action, code_value, code_length, output ready);
endinterface

interface jpbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// ===== design/jpeg_bit_packer_byte_stuffing_core.sv =====
`default_nettype none
// JPEG scan bit packer with byte stuffing.
// in_i  : one beat per code. action=0 appends code_length (saturated at 16)
//         bits of code_value, MSB first; action=1 pads the open byte with ones
//         and emits it.
// out_o : one beat per scan byte. Every 0xFF is followed by a stuffed 0x00.
//         last marks the final byte produced by one input beat.
// Latency: the first output byte of an item is valid the cycle after the
//         input beat is taken.
// Throughput: one input beat per cycle while each item yields at most one
//         byte and out_o.ready is high. An item that yields k bytes (up to 4:
//         two full bytes, each possibly stuffed) holds the input while the
//         output port drains one byte per cycle (with out_o.ready high) from
//         the result buffer; the next input is taken in the same cycle the
//         last byte leaves. Items yielding no byte give no output beat.
// Stall: while out_o.ready is low the result buffer holds its bytes steady
//         and in_i.ready stays low once the buffer has anything left.
// Reset: asynchronous, active low; clears the open byte to zero, sets the
//         next free bit to position 7 (MSB) and empties the result buffer.
module jpeg_bit_packer_byte_stuffing_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jpbp_in_if.sink    in_i,
  jpbp_out_if.source out_o
);
  import jpbp_pkg::*;

  // bit-assembly state
  logic [ByteW-1:0] pend_q, pend_d;
  logic [2:0]       free_q, free_d;

  // result buffer, entry 0 is presented on the port
  logic [ByteW-1:0] buf_q [MaxBeats];
  logic [ByteW-1:0] buf_d [MaxBeats];
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic in_fire, out_fire;

  // per-item packing
  logic [LenW-1:0]  len_sat;
  logic [16:0]      mask17;
  logic [CodeW-1:0] code_m;
  logic [2:0]       n_pend;
  logic [LenW-1:0]  total;
  logic [LenW-1:0]  shamt;
  logic [AccW-1:0]  acc;
  logic [8:0]       pad9;
  logic [ByteW-1:0] byte0, byte1;
  logic [1:0]       n_full;
  logic             stuff0, stuff1;
  logic [CntW-1:0]  new_cnt;

  assign out_o.valid    = (cnt_q != '0);
  assign out_o.out_byte = buf_q[0];
  assign out_o.last     = (cnt_q == CntW'(1));
  assign out_fire       = out_o.valid & out_o.ready;

  // free once the buffer is empty or its last byte is leaving now
  assign in_i.ready = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_o.ready);
  assign in_fire    = in_i.valid & in_i.ready;

  always_comb begin
    len_sat = (in_i.code_length > MaxCodeLen) ? MaxCodeLen : in_i.code_length;
    mask17  = (17'd1 << len_sat) - 17'd1;
    code_m  = in_i.code_value & mask17[CodeW-1:0];
    n_pend  = ~free_q;                       // bits already in the open byte
    total   = LenW'(n_pend) + len_sat;       // at most 23
    shamt   = LenW'(AccW) - total;           // 1 .. 24
    acc     = {pend_q, 16'h0000} | (AccW'(code_m) << shamt);
    pad9    = (9'd2 << free_q) - 9'd1;       // ones in bits free..0

    if (action_e'(in_i.action) == ACT_FLUSH) begin
      byte0  = pend_q | pad9[ByteW-1:0];
      byte1  = '0;
      n_full = 2'd1;
      pend_d = '0;
      free_d = TopBitIdx;
    end else begin
      byte0  = acc[23:16];
      byte1  = acc[15:8];
      n_full = total[4:3];
      free_d = ~total[2:0];
      unique case (n_full)
        2'd0:    pend_d = acc[23:16];
        2'd1:    pend_d = acc[15:8];
        default: pend_d = acc[7:0];
      endcase
    end

    stuff0 = (byte0 == ByteAllOnes);
    stuff1 = (byte1 == ByteAllOnes);

    unique case (n_full)
      2'd0:    new_cnt = '0;
      2'd1:    new_cnt = CntW'(1) + CntW'(stuff0);
      default: new_cnt = CntW'(2) + CntW'(stuff0) + CntW'(stuff1);
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxBeats; i++) begin
      buf_d[i] = buf_q[i];
    end
    if (in_fire) begin
      // byte0, [0x00], byte1, [0x00]; unused slots may hold leftover bits
      buf_d[0] = byte0;
      buf_d[1] = stuff0 ? 8'h00 : byte1;
      buf_d[2] = stuff0 ? byte1 : 8'h00;
      buf_d[3] = 8'h00;
      cnt_d    = new_cnt;
    end else if (out_fire) begin
      for (int i = 0; i < MaxBeats - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      free_q <= TopBitIdx;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        pend_q <= pend_d;
        free_q <= free_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxBeats; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

endmodule
`default_nettype wire

// ===== design/jpbp_checker.sv =====
`default_nettype none
module jpbp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       in_action_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i
);
  import jpbp_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("output beat changed under stall");

  // 0xFF is always followed by its stuffed zero from the same item
  a_ff_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_byte_i == ByteAllOnes) |-> !out_last_i)
    else $error("0xFF flagged as final byte");

  // a new item only enters once the previous item's bytes are gone
  a_in_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || (out_ready_i && out_last_i))
    else $error("input taken while results pending");

  // a flush always yields a byte
  a_flush_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (action_e'(in_action_i) == ACT_FLUSH) |=> out_valid_i)
    else $error("flush gave no output");

endmodule

bind jpeg_bit_packer_byte_stuffing_core jpbp_checker u_jpbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.last)
);
`default_nettype wire
